/* hw/rtl/pwmcma_pkg.sv */
// Shared widths, command codes, saturation limits and divider handshake types.
`default_nettype none

package pwmcma_pkg;

   localparam int unsigned TS_W      = 32;   // timestamp and tick measurements
   localparam int unsigned WIN_W     = 5;    // window length register
   localparam int unsigned DUTY_W    = 17;   // duty cycle, Q0.16 plus the 1.0 code
   localparam int unsigned DUTY_FRAC = 16;
   localparam int unsigned VEL_W     = 32;
   localparam int unsigned DEND_W    = 48;   // divider dividend and quotient
   localparam int unsigned DVS_W     = 32;   // divider divisor

   localparam logic [WIN_W-1:0]  WIN_RESET = 5'd16;
   localparam logic [DUTY_W-1:0] DUTY_ONE  = 17'h1_0000;

   localparam logic CMD_RISE = 1'b0;
   localparam logic CMD_FALL = 1'b1;

   localparam logic [VEL_W-1:0]  VEL_MAX     = 32'h7FFF_FFFF;
   localparam logic [VEL_W-1:0]  VEL_MIN     = 32'h8000_0000;
   localparam logic [DEND_W-1:0] VEL_POS_LIM = 48'h0000_7FFF_FFFF;
   localparam logic [DEND_W-1:0] VEL_NEG_LIM = 48'h0000_8000_0000;

   typedef struct packed {
      logic              start;
      logic [DEND_W-1:0] dividend;
      logic [DVS_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/pwmcma_req_if.sv */
// Edge event channel: valid/ready handshake with edge kind and timestamp.
`default_nettype none

interface pwmcma_req_if;
   import pwmcma_pkg::*;

   logic            valid;
   logic            ready;
   logic            cmd;
   logic [TS_W-1:0] timestamp;

   modport source (output valid, output cmd, output timestamp, input ready);
   modport sink   (input valid, input cmd, input timestamp, output ready);

endinterface

`default_nettype wire

/* hw/rtl/pwmcma_rsp_if.sv */
// Measurement result channel: valid/ready handshake with raw, averaged and duty figures.
`default_nettype none

interface pwmcma_rsp_if;
   import pwmcma_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [TS_W-1:0]         period_ticks;
   logic [TS_W-1:0]         pulse_ticks;
   logic [TS_W-1:0]         avg_period;
   logic [TS_W-1:0]         avg_pulse;
   logic [DUTY_W-1:0]       duty_q16;
   logic signed [VEL_W-1:0] duty_velocity;

   modport source (output valid, output period_ticks, output pulse_ticks,
                   output avg_period, output avg_pulse, output duty_q16,
                   output duty_velocity, input ready);
   modport sink   (input valid, input period_ticks, input pulse_ticks,
                   input avg_period, input avg_pulse, input duty_q16,
                   input duty_velocity, output ready);

endinterface

`default_nettype wire

/* hw/rtl/pwmcma_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pwmcma_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/pwmcma_div.sv */
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module pwmcma_div (
   input  logic                     clock,
   input  logic                     reset,
   input  pwmcma_pkg::div_req_type  div_req,
   output pwmcma_pkg::div_rsp_type  div_rsp
);
   import pwmcma_pkg::*;

   localparam int unsigned CNT_W = $clog2(DEND_W + 1);

   logic [CNT_W-1:0]  cnt_ff;
   logic              done_ff;
   logic [DVS_W-1:0]  rem_ff;
   logic [DEND_W-1:0] quo_ff;
   logic [DVS_W-1:0]  dvs_ff;

   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              fits;

   // shift the next dividend bit into the partial remainder and try the subtract
   assign trial = {rem_ff, quo_ff[DEND_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CNT_W'(1));
         if (div_req.start) begin
            cnt_ff <= CNT_W'(DEND_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         dvs_ff <= div_req.divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_ff <= {quo_ff[DEND_W-2:0], fits};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (cnt_ff == '0))
      else $error("divider started while busy");

   a_start_load: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> (cnt_ff == CNT_W'(DEND_W)))
      else $error("divider did not load its step count");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (cnt_ff == '0))
      else $error("divider flagged done while still stepping");

endmodule

`default_nettype wire

/* hw/rtl/pwm_capture_moving_average.sv */
// Top level: PWM edge capture with moving-average period, pulse, duty and duty velocity.
`default_nettype none

// PWM input capture with moving averages. Each input word is an edge event
// (cmd 0 rising, cmd 1 falling) carrying a free-running 32-bit tick timestamp;
// differences are taken modulo 2^32. A rising edge measures the period since
// the previous rising edge, a falling edge the high time since the latest
// rising edge. Each measurement replaces the slot at the shared ring index in
// its own store (period or pulse) and updates that store's running total; the
// average is total / window, truncated and saturated to 32 bits. A rising edge
// emits no word. A falling edge emits one word: the latest raw period and
// pulse, both averages, the averaged duty cycle in Q0.16 (capped at 1.0, i.e.
// 65536) and the duty change per second, (duty - previous duty) * TICK_HZ /
// average period, truncated toward zero and saturated to int32. With an
// average period of zero, duty and velocity are zero. The window length
// (csr_wr_data, 1..MAX_WINDOW; 0 acts as 1, larger values as MAX_WINDOW) is
// to be written by the user only while the block is idle; the block itself
// does not enforce this. Shrinking it does not clear the stores. Both stores
// start as all zero: a valid bit per entry masks RAM contents not yet written,
// so no clearing pass is needed after reset. All divisions go through one
// shared divider producing one quotient bit per cycle. A rising edge occupies
// the block for one division, a falling edge for three divisions and one
// multiply, or one division when the average period is zero. A finished result
// waits in the output register while the next edge is taken; a falling edge
// only stalls at its end if that register is still full.
module pwm_capture_moving_average #(
   parameter int unsigned MAX_WINDOW = 16,
   parameter int unsigned TICK_HZ    = 1000000
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [pwmcma_pkg::WIN_W-1:0] csr_wr_data,
   pwmcma_req_if.sink                  req,
   pwmcma_rsp_if.source                rsp
);
   import pwmcma_pkg::*;

   localparam int unsigned IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int unsigned TOT_W  = TS_W + $clog2(MAX_WINDOW);
   localparam int unsigned TICK_W = $clog2(TICK_HZ + 1);
   localparam int unsigned PROD_W = DUTY_W + TICK_W;
   localparam logic [TICK_W-1:0] TICK_C = TICK_W'(TICK_HZ);

   // sequencer codes
   localparam logic [2:0] S_IDLE = 3'd0;  // wait for an edge
   localparam logic [2:0] S_SUM  = 3'd1;  // replace slot, update total, start average
   localparam logic [2:0] S_AVG  = 3'd2;  // wait for the average
   localparam logic [2:0] S_DUTY = 3'd3;  // wait for the duty quotient
   localparam logic [2:0] S_MUL  = 3'd4;  // scale duty change by the tick rate
   localparam logic [2:0] S_VEL  = 3'd5;  // wait for the velocity quotient
   localparam logic [2:0] S_OUT  = 3'd6;  // hand the word to the output register

   logic [2:0]            state_ff;
   logic [WIN_W-1:0]      window_ff;
   logic [TS_W-1:0]       last_rise_ff;
   logic [TS_W-1:0]       last_period_ff;
   logic [TOT_W-1:0]      per_tot_ff;
   logic [TOT_W-1:0]      pul_tot_ff;
   logic [IDX_W-1:0]      ring_ff;
   logic [TS_W-1:0]       avg_per_ff;
   logic [DUTY_W-1:0]     prev_duty_ff;
   logic [MAX_WINDOW-1:0] per_vld_ff;
   logic [MAX_WINDOW-1:0] pul_vld_ff;

   // per-item working registers
   logic                  cmd_ff;
   logic [TS_W-1:0]       sample_ff;
   logic [TS_W-1:0]       avg_pul_ff;
   logic [DUTY_W-1:0]     duty_ff;
   logic                  neg_ff;
   logic [DUTY_W-1:0]     mag_ff;
   logic [VEL_W-1:0]      vel_ff;

   // output register
   logic                  rsp_vld_ff;
   logic [TS_W-1:0]       rsp_per_ff;
   logic [TS_W-1:0]       rsp_pul_ff;
   logic [TS_W-1:0]       rsp_avgper_ff;
   logic [TS_W-1:0]       rsp_avgpul_ff;
   logic [DUTY_W-1:0]     rsp_duty_ff;
   logic [VEL_W-1:0]      rsp_vel_ff;

   logic                  accept;
   logic [WIN_W-1:0]      eff_win;
   logic [TS_W-1:0]       per_rd;
   logic [TS_W-1:0]       pul_rd;
   logic [TS_W-1:0]       old_val;
   logic [TOT_W-1:0]      tot_in;
   logic [TS_W-1:0]       avg_in;
   logic [DUTY_W-1:0]     duty_in;
   logic                  neg_in;
   logic [DUTY_W-1:0]     mag_in;
   logic [VEL_W-1:0]      vel_in;
   logic [PROD_W-1:0]     prod;
   logic [IDX_W-1:0]      ring_in;
   logic                  out_free;
   logic                  per_we;
   logic                  pul_we;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   assign accept   = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign out_free = !rsp_vld_ff || rsp.ready;

   // clamp the window into 1..MAX_WINDOW
   always_comb begin
      if (window_ff == '0) begin
         eff_win = WIN_W'(1);
      end else if (32'(window_ff) > 32'(MAX_WINDOW)) begin
         eff_win = WIN_W'(MAX_WINDOW);
      end else begin
         eff_win = window_ff;
      end
   end

   // ---- sample stores: both read at the ring slot every cycle ----
   assign per_we = (state_ff == S_SUM) && (cmd_ff == CMD_RISE);
   assign pul_we = (state_ff == S_SUM) && (cmd_ff == CMD_FALL);

   pwmcma_ram #(.WIDTH(TS_W), .DEPTH(MAX_WINDOW)) u_per_ram (
      .clock   (clock),
      .wr_en   (per_we),
      .wr_addr (ring_ff),
      .wr_data (sample_ff),
      .rd_addr (ring_ff),
      .rd_data (per_rd)
   );

   pwmcma_ram #(.WIDTH(TS_W), .DEPTH(MAX_WINDOW)) u_pul_ram (
      .clock   (clock),
      .wr_en   (pul_we),
      .wr_addr (ring_ff),
      .wr_data (sample_ff),
      .rd_addr (ring_ff),
      .rd_data (pul_rd)
   );

   // an entry never written reads as zero
   always_comb begin
      if (cmd_ff == CMD_RISE) begin
         old_val = per_vld_ff[ring_ff] ? per_rd : '0;
         tot_in  = per_tot_ff - TOT_W'(old_val) + TOT_W'(sample_ff);
      end else begin
         old_val = pul_vld_ff[ring_ff] ? pul_rd : '0;
         tot_in  = pul_tot_ff - TOT_W'(old_val) + TOT_W'(sample_ff);
      end
   end

   // ---- quotient post-processing ----
   assign avg_in  = (div_rsp.quotient[DEND_W-1:TS_W] != '0) ? '1
                                                           : div_rsp.quotient[TS_W-1:0];
   assign duty_in = (div_rsp.quotient > DEND_W'(DUTY_ONE)) ? DUTY_ONE
                                                          : div_rsp.quotient[DUTY_W-1:0];
   assign neg_in  = (duty_in < prev_duty_ff);
   assign mag_in  = neg_in ? (prev_duty_ff - duty_in) : (duty_in - prev_duty_ff);
   assign prod    = PROD_W'(mag_ff) * PROD_W'(TICK_C);

   always_comb begin
      if (neg_ff) begin
         vel_in = (div_rsp.quotient >= VEL_NEG_LIM) ? VEL_MIN
                                                    : (VEL_W'(0) - div_rsp.quotient[VEL_W-1:0]);
      end else begin
         vel_in = (div_rsp.quotient > VEL_POS_LIM) ? VEL_MAX : div_rsp.quotient[VEL_W-1:0];
      end
   end

   // advance the ring, wrapping at the window
   assign ring_in = ((32'(ring_ff) + 32'd1) >= 32'(eff_win)) ? '0 : (ring_ff + IDX_W'(1));

   // ---- shared divider feed ----
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = DEND_W'(prod);
      div_req.divisor  = avg_per_ff;
      unique case (state_ff)
         S_SUM: begin
            div_req.start    = 1'b1;
            div_req.dividend = DEND_W'(tot_in);
            div_req.divisor  = DVS_W'(eff_win);
         end
         S_AVG: begin
            div_req.start    = div_rsp.done && (cmd_ff == CMD_FALL) && (avg_per_ff != '0);
            div_req.dividend = DEND_W'({avg_in, {DUTY_FRAC{1'b0}}});
         end
         S_MUL: begin
            div_req.start = 1'b1;
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   pwmcma_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---- sequencer and persistent state ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         window_ff      <= WIN_RESET;
         last_rise_ff   <= '0;
         last_period_ff <= '0;
         per_tot_ff     <= '0;
         pul_tot_ff     <= '0;
         ring_ff        <= '0;
         avg_per_ff     <= '0;
         prev_duty_ff   <= '0;
         per_vld_ff     <= '0;
         pul_vld_ff     <= '0;
         rsp_vld_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end

         // load a finished word, or drop the one just taken
         if ((state_ff == S_OUT) && out_free) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_vld_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_SUM;
                  if (req.cmd == CMD_RISE) begin
                     last_rise_ff   <= req.timestamp;
                     last_period_ff <= req.timestamp - last_rise_ff;
                  end
               end
            end
            S_SUM: begin
               state_ff <= S_AVG;
               if (cmd_ff == CMD_RISE) begin
                  per_tot_ff          <= tot_in;
                  per_vld_ff[ring_ff] <= 1'b1;
               end else begin
                  pul_tot_ff          <= tot_in;
                  pul_vld_ff[ring_ff] <= 1'b1;
               end
            end
            S_AVG: begin
               if (div_rsp.done) begin
                  if (cmd_ff == CMD_RISE) begin
                     avg_per_ff <= avg_in;
                     state_ff   <= S_IDLE;
                  end else if (avg_per_ff != '0) begin
                     state_ff <= S_DUTY;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end
            end
            S_DUTY: begin
               if (div_rsp.done) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               state_ff <= S_VEL;
            end
            S_VEL: begin
               if (div_rsp.done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  prev_duty_ff <= duty_ff;
                  ring_ff      <= ring_in;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // ---- working and output payload ----
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req.cmd;
         sample_ff <= req.timestamp - last_rise_ff;
      end

      if ((state_ff == S_AVG) && div_rsp.done) begin
         avg_pul_ff <= avg_in;
         // zero average period: duty and velocity stay zero
         duty_ff    <= '0;
         vel_ff     <= '0;
      end

      if ((state_ff == S_DUTY) && div_rsp.done) begin
         duty_ff <= duty_in;
         neg_ff  <= neg_in;
         mag_ff  <= mag_in;
      end

      if ((state_ff == S_VEL) && div_rsp.done) begin
         vel_ff <= vel_in;
      end

      if ((state_ff == S_OUT) && out_free) begin
         rsp_per_ff    <= last_period_ff;
         rsp_pul_ff    <= sample_ff;
         rsp_avgper_ff <= avg_per_ff;
         rsp_avgpul_ff <= avg_pul_ff;
         rsp_duty_ff   <= duty_ff;
         rsp_vel_ff    <= vel_ff;
      end
   end

   assign rsp.valid         = rsp_vld_ff;
   assign rsp.period_ticks  = rsp_per_ff;
   assign rsp.pulse_ticks   = rsp_pul_ff;
   assign rsp.avg_period    = rsp_avgper_ff;
   assign rsp.avg_pulse     = rsp_avgpul_ff;
   assign rsp.duty_q16      = rsp_duty_ff;
   assign rsp.duty_velocity = rsp_vel_ff;

   // ---- checks ----
   a_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_AVG) || (state_ff == S_DUTY) || (state_ff == S_VEL))
      else $error("divider finished with no step waiting for it");

   a_duty_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_duty_ff <= DUTY_ONE))
      else $error("duty above 1.0 on the output");

   a_zero_period: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && (rsp_avgper_ff == '0) |-> (rsp_duty_ff == '0) && (rsp_vel_ff == '0))
      else $error("non-zero duty or velocity with zero average period");

   a_rise_silent: assert property (@(posedge clock) disable iff (reset)
      accept && (req.cmd == CMD_RISE) |=> !$rose(rsp_vld_ff))
      else $error("rising edge produced an output word");

endmodule

`default_nettype wire
